// ===== src/icmpm_pkg.sv =====
// ============================================================================
// icmpm_pkg
// Shared types, constants and helpers of the ICMP echo reply matcher.
// ============================================================================
package icmpm_pkg;

    // Default width of the per-packet byte counter.
    localparam int COUNT_BITS_DEF = 16;

    // Packet layout constants.
    localparam int MIN_V4_LEN    = 20;
    localparam int MIN_V6_LEN    = 40;
    localparam int V6_OFFSET     = 40;
    localparam int ECHO_LEN      = 8;
    localparam int V4_REPLY_TYPE = 0;
    localparam int V6_REPLY_TYPE = 129;
    localparam int OFF_BITS      = 6;
    localparam int FIELD_BITS    = 48;

    localparam logic [3:0] IHL_MASK   = 4'hF;
    localparam logic [3:0] V4_VERSION = 4'd4;
    localparam logic [3:0] V6_VERSION = 4'd6;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FAMILY   = 2'd0,
        CFG_IDENT    = 2'd1,
        CFG_SEQUENCE = 2'd2
    } t_cfg_index;

    // Snapshot of the captured header state, with the current byte merged in.
    typedef struct packed {
        logic [7:0]            lead_byte;
        logic [OFF_BITS-1:0]   icmp_offset;
        logic [FIELD_BITS-1:0] bare_fields;
        logic [FIELD_BITS-1:0] header_fields;
    } t_icmp_view;

    // Place a byte at ICMP position rel into a field store laid out as
    // type[47:40], code[39:32], id[31:16], seq[15:0]. The checksum bytes
    // at positions 2 and 3 are not kept.
    function automatic logic [FIELD_BITS-1:0] put_field(
        input logic [FIELD_BITS-1:0] store,
        input logic [2:0]            rel,
        input logic [7:0]            data
    );
        logic [FIELD_BITS-1:0] result;
        result = store;
        case (rel)
            3'd0:    result[47:40] = data;
            3'd1:    result[39:32] = data;
            3'd4:    result[31:24] = data;
            3'd5:    result[23:16] = data;
            3'd6:    result[15:8]  = data;
            3'd7:    result[7:0]   = data;
            default: result = store;
        endcase
        return result;
    endfunction

endpackage

// ===== src/icmp_echo_reply_matcher.sv =====
// ============================================================================
// icmp_echo_reply_matcher
// Byte-stream ICMP echo reply matcher for IPv4 and IPv6 receive paths.
// ============================================================================
// Usage:
// Packet bytes enter on the input channel (i_in_valid / o_in_ready), one
// item per byte with i_end_of_packet set on the last byte. Each packet gives
// exactly one result item on the output channel (o_out_valid / i_out_ready),
// o_reply_matches, telling whether it is the expected echo reply.
// Configuration is written through its own channel (i_cfg_valid /
// o_cfg_ready, always ready); the user writes it only while no packet is in
// flight, which the block does not enforce. Throughput is one byte per cycle
// but for the final-byte stall below. A byte is held in an input register
// while the capture and compare logic works on it; a final byte's result
// goes on to a separate result register. While a result waits, non-final
// bytes keep flowing; only a final byte stalls, in the input register, until
// the waiting result is taken. Reset (synchronous, active low) clears the
// configuration, the byte counter, the captured fields and both stages.
// ============================================================================
module icmp_echo_reply_matcher #(
    parameter int COUNT_BITS = icmpm_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Packet byte channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_end_of_packet,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_reply_matches,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import icmpm_pkg::*;

    // Configuration registers.
    logic        r_family;
    logic [15:0] r_ident;
    logic [15:0] r_sequence;

    // Input register stage.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eop;

    // Result register stage.
    logic        r_out_valid;
    logic        r_out_match;

    logic                  w_out_free;
    logic                  w_stage_fire;
    logic [COUNT_BITS-1:0] w_pos;
    t_icmp_view            w_view;
    logic                  w_match;

    // A non-final byte always retires; a final byte needs the result slot.
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_stage_fire = r_in_valid && (!r_in_eop || w_out_free);
    assign o_in_ready   = !r_in_valid || w_stage_fire;
    assign o_cfg_ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family   <= 1'b0;
            r_ident    <= '0;
            r_sequence <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FAMILY:   r_family   <= i_cfg_data[0];
                CFG_IDENT:    r_ident    <= i_cfg_data;
                CFG_SEQUENCE: r_sequence <= i_cfg_data;
                default:      r_family   <= r_family;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_packet_byte;
            r_in_eop  <= i_end_of_packet;
        end
    end

    icmpm_capture #(
        .COUNT_BITS (COUNT_BITS)
    ) u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_stage_fire),
        .i_byte   (r_in_byte),
        .i_eop    (r_in_eop),
        .i_family (r_family),
        .o_pos    (w_pos),
        .o_view   (w_view)
    );

    icmpm_decide #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decide (
        .i_pos      (w_pos),
        .i_view     (w_view),
        .i_family   (r_family),
        .i_ident    (r_ident),
        .i_sequence (r_sequence),
        .o_match    (w_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stage_fire && r_in_eop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stage_fire && r_in_eop) begin
            r_out_match <= w_match;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_reply_matches = r_out_match;

`ifndef SYNTHESIS
    // The last byte of a packet produces a result and restarts the counter.
    a_eop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage_fire && r_in_eop) |=> (o_out_valid && w_pos == '0))
        else $error("last byte did not produce a result or clear the counter");

    // A final byte may not leave the input stage while a result is stalled.
    a_eop_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_eop && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("final byte overran a waiting result");

    // The byte counter holds at its maximum instead of wrapping.
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage_fire && !r_in_eop && w_pos == '1) |=> (w_pos == '1))
        else $error("byte counter wrapped");
`endif

endmodule

// ===== src/icmpm_capture.sv =====
// ============================================================================
// icmpm_capture
// Per-packet byte counter and capture of the ICMP echo header bytes.
// ============================================================================
module icmpm_capture #(
    parameter int COUNT_BITS = icmpm_pkg::COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    input  logic                   i_eop,
    input  logic                   i_family,
    output logic [COUNT_BITS-1:0]  o_pos,
    output icmpm_pkg::t_icmp_view  o_view
);
    import icmpm_pkg::*;

    logic [COUNT_BITS-1:0] r_pos,  n_pos;
    logic [7:0]            r_lead, n_lead;
    logic [OFF_BITS-1:0]   r_off,  n_off;
    logic [FIELD_BITS-1:0] r_bare, n_bare;
    logic [FIELD_BITS-1:0] r_hdr,  n_hdr;
    logic [COUNT_BITS-1:0] w_rel;

    always_comb begin
        n_lead = r_lead;
        n_off  = r_off;
        // The first byte fixes the version nibble and where ICMP starts.
        if (r_pos == '0) begin
            n_lead = i_byte;
            n_off  = i_family ? OFF_BITS'(V6_OFFSET) : {i_byte[3:0] & IHL_MASK, 2'b00};
        end

        n_bare = r_bare;
        if (r_pos < COUNT_BITS'(ECHO_LEN)) begin
            n_bare = put_field(r_bare, r_pos[2:0], i_byte);
        end

        w_rel = r_pos - COUNT_BITS'(n_off);
        n_hdr = r_hdr;
        if (r_pos >= COUNT_BITS'(n_off) && w_rel < COUNT_BITS'(ECHO_LEN)) begin
            n_hdr = put_field(r_hdr, w_rel[2:0], i_byte);
        end

        // The counter saturates instead of wrapping.
        n_pos = (r_pos == '1) ? r_pos : r_pos + COUNT_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_lead <= '0;
            r_off  <= '0;
            r_bare <= '0;
            r_hdr  <= '0;
        end else if (i_step) begin
            if (i_eop) begin
                r_pos  <= '0;
                r_lead <= '0;
                r_off  <= '0;
                r_bare <= '0;
                r_hdr  <= '0;
            end else begin
                r_pos  <= n_pos;
                r_lead <= n_lead;
                r_off  <= n_off;
                r_bare <= n_bare;
                r_hdr  <= n_hdr;
            end
        end
    end

    assign o_pos                = r_pos;
    assign o_view.lead_byte     = n_lead;
    assign o_view.icmp_offset   = n_off;
    assign o_view.bare_fields   = n_bare;
    assign o_view.header_fields = n_hdr;

endmodule

// ===== src/icmpm_decide.sv =====
// ============================================================================
// icmpm_decide
// Judges on the last byte whether the packet is the expected echo reply.
// ============================================================================
module icmpm_decide #(
    parameter int COUNT_BITS = icmpm_pkg::COUNT_BITS_DEF
) (
    input  logic [COUNT_BITS-1:0]  i_pos,
    input  icmpm_pkg::t_icmp_view  i_view,
    input  logic                   i_family,
    input  logic [15:0]            i_ident,
    input  logic [15:0]            i_sequence,
    output logic                   o_match
);
    import icmpm_pkg::*;

    logic                  w_hdr;
    logic                  w_room;
    logic [7:0]            w_want_type;
    logic [FIELD_BITS-1:0] w_fields;

    // Lengths are compared as position of the last byte, one less than length.
    always_comb begin
        if (i_family) begin
            w_hdr = (i_pos >= COUNT_BITS'(MIN_V6_LEN - 1)) &&
                    (i_view.lead_byte[7:4] == V6_VERSION);
            w_want_type = 8'(V6_REPLY_TYPE);
        end else begin
            w_hdr = (i_pos >= COUNT_BITS'(MIN_V4_LEN - 1)) &&
                    (i_view.lead_byte[7:4] == V4_VERSION);
            w_want_type = 8'(V4_REPLY_TYPE);
        end

        if (w_hdr) begin
            w_room   = i_pos >= (COUNT_BITS'(i_view.icmp_offset) + COUNT_BITS'(ECHO_LEN - 1));
            w_fields = i_view.header_fields;
        end else begin
            w_room   = i_pos >= COUNT_BITS'(ECHO_LEN - 1);
            w_fields = i_view.bare_fields;
        end

        o_match = w_room &&
                  (w_fields[47:40] == w_want_type) &&
                  (w_fields[39:32] == 8'h00) &&
                  (w_fields[31:16] == i_ident) &&
                  (w_fields[15:0]  == i_sequence);
    end

endmodule

// ===== tb/sv/tb_icmp_echo_reply_matcher.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_icmp_echo_reply_matcher
// Self-checking bench for the ICMP echo reply matcher. Whole packets are
// queued as byte items and fed through the valid/ready input channel. A
// behavioral copy of the matcher tracks every accepted byte. On each final
// byte it queues the match flag that the block must return, and each result
// item is checked against the oldest queued flag.
// ============================================================================
module tb_icmp_echo_reply_matcher;
    import icmpm_pkg::*;

    // A narrow byte counter lets a short packet reach saturation.
    localparam int CNT_BITS     = 7;
    localparam int LONG_LEN     = 160;       // Runs well past counter saturation.
    localparam int RAND_BYTES   = 800;
    localparam int RAND_PHASES  = 8;
    localparam int SETTLE       = 4;         // Cycles of quiet before a config write.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam logic [7:0] ECHO_REQUEST = 8'd8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // One packet byte as the driver presents it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_packet_byte   = 8'd0;
    logic        i_end_of_packet = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic        o_reply_matches;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index     = CFG_FAMILY;
    logic [15:0] i_cfg_data      = 16'd0;

    icmp_echo_reply_matcher #(
        .COUNT_BITS (CNT_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_packet_byte   (i_packet_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_reply_matches (o_reply_matches),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    t_byte_item byte_q[$];              // Bytes waiting to be driven.
    logic       expected_match_q[$];    // Match flags owed by the block.
    logic [7:0] pkt [0:127];            // Scratch buffer for building a packet.

    t_idle_mode  idle_mode   = IDLE_NONE;
    logic        ph_family   = 1'b0;    // Register values of the current phase.
    logic [15:0] ph_ident    = 16'd0;
    logic [15:0] ph_seq      = 16'd0;

    logic        in_taken    = 1'b0;    // The driven byte was accepted at the last edge.
    int          cycle_count = 0;
    int          bytes_queued = 0;
    int          bytes_taken  = 0;
    int          packets_queued = 0;
    int          results_seen = 0;
    int          matches_seen = 0;
    int          mismatches   = 0;

    // Mirror of the configuration registers, updated on each accepted write.
    logic        cfg_family;
    logic [15:0] cfg_ident;
    logic [15:0] cfg_seq;

    // Mirror of the per-packet capture state.
    logic [CNT_BITS-1:0] chk_count;
    logic [7:0]          chk_lead;
    logic [47:0]         chk_bare;
    logic [47:0]         chk_hdr;
    logic [5:0]          chk_off;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Stores an echo header byte at its ICMP position. The stores keep
    // type[47:40], code[39:32], identifier[31:16] and sequence[15:0]; the
    // checksum bytes at positions 2 and 3 are dropped.
    function automatic logic [47:0] place_byte(input logic [47:0] store,
                                               input int unsigned rel,
                                               input logic [7:0] b);
        int sh;
        if (rel == 2 || rel == 3 || rel > 7)
            return store;
        sh = (rel < 2) ? 40 - 8 * rel : 56 - 8 * rel;
        return (store & ~(48'hFF << sh)) | (48'(b) << sh);
    endfunction

    task automatic clear_packet_state();
        chk_count = '0;
        chk_lead  = 8'd0;
        chk_bare  = 48'd0;
        chk_hdr   = 48'd0;
        chk_off   = 6'd0;
    endtask

    // Follows one accepted byte. The ICMP offset is fixed from the family
    // register at the first byte, while the version and type rules use the
    // family register as it stands at the final byte.
    task automatic track_byte(input logic [7:0] b, input logic last);
        int unsigned pos;
        int unsigned len;
        logic [3:0]  ver;
        logic [7:0]  want_type;
        logic [47:0] fields;
        bit          hdr;
        bit          ok;
        pos = chk_count;
        if (pos == 0) begin
            chk_lead = b;
            chk_off  = cfg_family ? 6'(V6_OFFSET) : {b[3:0], 2'b00};
        end
        if (pos < ECHO_LEN)
            chk_bare = place_byte(chk_bare, pos, b);
        if (pos >= chk_off && pos - chk_off < ECHO_LEN)
            chk_hdr = place_byte(chk_hdr, pos - chk_off, b);
        // The counter sticks at all ones, so a very long packet is seen as
        // one byte longer than the saturated count.
        if (chk_count != '1)
            chk_count = chk_count + 1'b1;
        if (last) begin
            len = pos + 1;
            ver = chk_lead[7:4];
            if (cfg_family) begin
                hdr       = (len >= MIN_V6_LEN) && (ver == V6_VERSION);
                want_type = 8'(V6_REPLY_TYPE);
            end else begin
                hdr       = (len >= MIN_V4_LEN) && (ver == V4_VERSION);
                want_type = 8'(V4_REPLY_TYPE);
            end
            // A packet with a valid IP header must hold the whole echo header
            // behind it; anything else is read as bare ICMP from byte 0.
            fields = hdr ? chk_hdr : chk_bare;
            ok     = hdr ? (chk_off + ECHO_LEN <= len) : (len >= ECHO_LEN);
            ok     = ok && fields[47:40] == want_type && fields[39:32] == 8'd0 &&
                     fields[31:16] == cfg_ident && fields[15:0] == cfg_seq;
            expected_match_q.push_back(ok);
            clear_packet_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. Inputs change on the falling edge. A new byte is put up only
    // once the previous one was taken, and the receiver's ready is redrawn
    // every cycle according to the idle mode of the phase.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : feed
        t_byte_item item;
        bit         hold_in;
        bit         hold_out;
        hold_in  = (idle_mode == IDLE_SENDER && $urandom_range(99) < 76) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(99) < 9);
        hold_out = (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 76) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(99) < 9);
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (byte_q.size() != 0 && !hold_in) begin
                    item = byte_q.pop_front();
                    i_in_valid      <= 1'b1;
                    i_packet_byte   <= item.data;
                    i_end_of_packet <= item.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= !hold_out;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled on the rising edge. Results are checked
    // before the byte of the same edge is tracked, so a result can never be
    // paired with a packet that only just ended.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        logic want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("[icmp_echo_reply_matcher] ERROR");
            $finish;
        end else if (!i_rst_n) begin
            in_taken   <= 1'b0;
            cfg_family = 1'b0;
            cfg_ident  = 16'd0;
            cfg_seq    = 16'd0;
            clear_packet_state();
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FAMILY:   cfg_family = i_cfg_data[0];
                    CFG_IDENT:    cfg_ident  = i_cfg_data;
                    CFG_SEQUENCE: cfg_seq    = i_cfg_data;
                    default:      ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_match_q.size() == 0) begin
                    flag_mismatch("result item with no packet outstanding");
                end else begin
                    want = expected_match_q.pop_front();
                    results_seen++;
                    if (want)
                        matches_seen++;
                    if (o_reply_matches !== want)
                        flag_mismatch($sformatf("packet %0d: reply_matches %b, expected %b",
                                                results_seen, o_reply_matches, want));
                end
            end
            if (i_in_valid && o_in_ready) begin
                bytes_taken++;
                track_byte(i_packet_byte, i_end_of_packet);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Fills the scratch buffer with random bytes, lays the echo header at the
    // given offset where it fits, and puts the lead byte last so that it
    // wins when the offset is zero.
    task automatic form_packet(input logic [7:0] lead, input int off, input int len,
                               input logic [7:0] typ, input logic [7:0] code,
                               input logic [15:0] ident, input logic [15:0] seq);
        logic [63:0] echo;
        echo = {typ, code, 16'h0000, ident, seq};
        for (int i = 0; i < len; i++)
            pkt[i] = 8'($urandom);
        for (int i = 0; i < ECHO_LEN; i++)
            if (i != 2 && i != 3 && off + i < len)
                pkt[off + i] = echo[63 - 8 * i -: 8];
        pkt[0] = lead;
    endtask

    // Queues the scratch packet, followed by a random payload tail.
    task automatic queue_packet(input int len, input int tail);
        t_byte_item item;
        for (int i = 0; i < len + tail; i++) begin
            item.data = (i < len) ? pkt[i] : 8'($urandom);
            item.last = (i == len + tail - 1);
            byte_q.push_back(item);
        end
        bytes_queued += len + tail;
        packets_queued++;
    endtask

    // Waits until every byte is taken and every result is back, then lets
    // the pipeline settle before anything else happens.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (bytes_taken != bytes_queued || expected_match_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes all three registers back to back and sets the idle mode.
    task automatic start_phase(input t_idle_mode mode, input logic fam,
                               input logic [15:0] ident, input logic [15:0] seq);
        idle_mode = mode;
        ph_family = fam;
        ph_ident  = ident;
        ph_seq    = seq;
        for (int k = 0; k < 3; k++) begin
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            case (k)
                0: begin
                    i_cfg_index <= CFG_FAMILY;
                    i_cfg_data  <= {15'd0, fam};
                end
                1: begin
                    i_cfg_index <= CFG_IDENT;
                    i_cfg_data  <= ident;
                end
                default: begin
                    i_cfg_index <= CFG_SEQUENCE;
                    i_cfg_data  <= seq;
                end
            endcase
            do
                @(posedge i_clk);
            while (!o_cfg_ready);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random packet. Most are echo replies behind an IP header with
    // random content, mostly well formed; the rest are bare ICMP, truncated
    // packets and plain noise.
    task automatic random_packet();
        int          r;
        int          ihl;
        int          off;
        int          len;
        logic [7:0]  want_type;
        logic [7:0]  other_type;
        logic [7:0]  typ;
        logic [7:0]  code;
        logic [7:0]  lead;
        logic [15:0] ident;
        logic [15:0] seq;
        want_type  = ph_family ? 8'(V6_REPLY_TYPE) : 8'(V4_REPLY_TYPE);
        other_type = ph_family ? 8'(V4_REPLY_TYPE) : 8'(V6_REPLY_TYPE);
        r     = $urandom_range(99);
        typ   = ($urandom_range(9) < 8) ? want_type :
                ($urandom_range(1) ? other_type : 8'($urandom));
        code  = ($urandom_range(99) < 85) ? 8'd0 : 8'($urandom);
        ident = ($urandom_range(99) < 80) ? ph_ident : ph_ident ^ (16'd1 << $urandom_range(15));
        seq   = ($urandom_range(99) < 80) ? ph_seq : ph_seq ^ (16'd1 << $urandom_range(15));
        if (r < 60) begin
            if (ph_family) begin
                off  = V6_OFFSET;
                lead = {V6_VERSION, 4'($urandom)};
            end else begin
                // Mostly the plain 20-byte header, sometimes options, and now
                // and then an IHL below five that points inside the header.
                case ($urandom_range(9))
                    0:       ihl = $urandom_range(4);
                    1, 2:    ihl = $urandom_range(15, 6);
                    default: ihl = 5;
                endcase
                off  = ihl * 4;
                lead = {V4_VERSION, 4'(ihl)};
            end
            len = off + ECHO_LEN + $urandom_range(6);
            if ($urandom_range(9) == 0)
                len = $urandom_range(off + ECHO_LEN - 1, 1);
        end else if (r < 80) begin
            off  = 0;
            lead = typ;
            len  = ($urandom_range(9) == 0) ? $urandom_range(7, 1) : ECHO_LEN + $urandom_range(10);
        end else begin
            len  = $urandom_range(48, 1);
            off  = len;
            lead = $urandom_range(1) ? 8'($urandom) :
                   {($urandom_range(1) ? V4_VERSION : V6_VERSION), 4'($urandom)};
        end
        form_packet(lead, off, len, typ, code, ident, seq);
        queue_packet(len, 0);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence: reset, directed IPv4 and IPv6 packets, one packet long
    // enough to saturate the byte counter, then random phases that cycle
    // through both families and all flow-control mixes. Each phase starts
    // with the block idle and writes every register.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase_start;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // IPv4 rules with directed packets.
        start_phase(IDLE_NONE, 1'b0, 16'h1234, 16'hABCD);
        form_packet(8'h45, 20, 28, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(28, 0);                         // Plain reply: match.
        form_packet(8'h45, 20, 28, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq ^ 16'h0001);
        queue_packet(28, 0);                         // Wrong sequence number.
        form_packet(8'h45, 20, 28, 8'(V4_REPLY_TYPE), 8'd0, ph_ident ^ 16'h8000, ph_seq);
        queue_packet(28, 0);                         // Wrong identifier.
        form_packet(8'h45, 20, 28, ECHO_REQUEST, 8'd0, ph_ident, ph_seq);
        queue_packet(28, 0);                         // Echo request, not a reply.
        form_packet(8'h45, 20, 28, 8'(V4_REPLY_TYPE), 8'd1, ph_ident, ph_seq);
        queue_packet(28, 0);                         // Nonzero code.
        form_packet(8'(V4_REPLY_TYPE), 0, 8, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(8, 0);                          // Bare ICMP, shortest match.
        form_packet(8'(V4_REPLY_TYPE), 0, 7, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(7, 0);                          // One byte short of an echo header.
        form_packet(8'h45, 1, 1, 8'd0, 8'd0, ph_ident, ph_seq);
        queue_packet(1, 0);                          // Single-byte packet.
        form_packet(8'h42, 8, 20, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(20, 0);                         // Short IHL, header inside IP header.
        form_packet(8'h40, 0, 20, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(20, 0);                         // IHL of zero, offset zero.
        form_packet(8'h4F, 60, 40, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(40, 0);                         // Longest IHL, echo header cut off.
        form_packet(8'h4F, 60, 68, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(68, 0);                         // Longest IHL, complete.
        form_packet(8'h45, 20, 19, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(19, 0);                         // Version 4 but under 20 bytes.
        for (int i = 0; i < 8; i++)
            pkt[i] = 8'hFF;
        queue_packet(8, 0);                          // All ones.
        wait_idle();

        // IPv6 rules with directed packets and register extremes.
        start_phase(IDLE_NONE, 1'b1, 16'h0000, 16'hFFFF);
        form_packet(8'h60, 40, 48, 8'(V6_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(48, 0);                         // Plain IPv6 reply: match.
        form_packet(8'h60, 40, 48, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(48, 0);                         // IPv4 type under IPv6 rules.
        form_packet(8'h60, 40, 39, 8'(V6_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(39, 0);                         // Too short for an IPv6 header.
        form_packet(8'(V6_REPLY_TYPE), 0, 8, 8'(V6_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(8, 0);                          // Bare ICMPv6 reply: match.
        form_packet(8'h45, 20, 28, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(28, 0);                         // IPv4 packet under IPv6 rules.
        wait_idle();

        // A reply followed by enough payload to saturate the byte counter.
        start_phase(IDLE_NONE, 1'b0, 16'hFFFF, 16'h0000);
        form_packet(8'h45, 20, 28, 8'(V4_REPLY_TYPE), 8'd0, ph_ident, ph_seq);
        queue_packet(28, LONG_LEN - 28);
        wait_idle();

        // Random phases. Every so often the sender also drains the block
        // completely before the next packet.
        for (int k = 0; k < RAND_PHASES; k++) begin
            start_phase(t_idle_mode'(k / 2), 1'(k % 2),
                        (k == 2) ? 16'h0000 : (k == 3) ? 16'hFFFF : 16'($urandom),
                        (k == 2) ? 16'hFFFF : (k == 5) ? 16'h0000 : 16'($urandom));
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < RAND_BYTES / RAND_PHASES) begin
                if ($urandom_range(19) == 0)
                    wait_idle();
                random_packet();
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        $display("Ran %0d packets, %0d bytes, under IPv4 and IPv6 rules,",
                 packets_queued, bytes_queued);
        $display("with all stall mixes; %0d of %0d replies matched.",
                 matches_seen, results_seen);
        if (mismatches == 0 && expected_match_q.size() == 0) begin
            $display("[icmp_echo_reply_matcher] OK");
        end else begin
            $display("[icmp_echo_reply_matcher] ERROR");
        end
        $finish;
    end

endmodule
